[rtl/dvd_pkg.sv]
// shared types and constants of the depth varint delta decoder
package dvd_pkg;

   localparam int CodeByteWidth   = 8;
   localparam int PixelWidth      = 16;
   localparam int CountWidth      = 23;
   localparam int OffsetWidth     = 4;
   localparam int PayloadBits     = 3;
   localparam int ContinueBit     = 3;
   localparam int CodeMaxOffset   = 15;
   localparam int RspDataWidth    = 40;
   localparam int PixelCap        = 4194304;
   localparam int LimitWidth      = 25;
   localparam int FifoDepth       = 4;
   localparam int FifoAddrWidth   = 2;
   localparam int FifoCountWidth  = 3;
   localparam int PushCountWidth  = 2;

   localparam logic [CountWidth-1:0] PixelCountReset = CountWidth'(307200);

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic                  overflowed;
      logic [CountWidth-1:0] zero_fill;
      logic [PixelWidth-1:0] pixel_value;
   } result_type;

   typedef struct packed {
      logic [PushCountWidth-1:0] count;
      result_type                first;
      result_type                second;
   } push_type;

endpackage

[rtl/dvd_decode.sv]
// code gathering, zigzag delta reconstruction and frame summary
module dvd_decode #(
   parameter int PixelCap = dvd_pkg::PixelCap
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  logic [dvd_pkg::CodeByteWidth-1:0]     code_byte,
   input  logic                                  frame_end,
   input  logic [dvd_pkg::CountWidth-1:0]        pixel_count,
   output dvd_pkg::push_type                     push
);

   logic [dvd_pkg::PixelWidth-1:0]  code_accum_ff, code_accum_in;
   logic [dvd_pkg::OffsetWidth-1:0] bit_offset_ff, bit_offset_in;
   logic [dvd_pkg::PixelWidth-1:0]  last_pixel_ff, last_pixel_in;
   logic [dvd_pkg::CountWidth-1:0]  pixels_done_ff, pixels_done_in;
   logic                            dropping_ff, dropping_in;

   logic [dvd_pkg::PixelWidth-1:0]  payload_shifted;
   logic [dvd_pkg::PixelWidth-1:0]  code_word;
   logic [dvd_pkg::PixelWidth-1:0]  diff;
   logic [dvd_pkg::PixelWidth-1:0]  pixel_sum;
   logic [dvd_pkg::LimitWidth-1:0]  max_wide;
   logic [dvd_pkg::CountWidth-1:0]  limit;
   logic [dvd_pkg::CountWidth-1:0]  done_after;
   logic [dvd_pkg::CountWidth-1:0]  fill;
   logic                            finish;
   logic                            at_limit;
   logic                            emit;
   logic                            drop_now;
   logic                            drop_after;
   dvd_pkg::result_type             pixel_res;
   dvd_pkg::result_type             summary_res;

   always_comb begin
      max_wide = dvd_pkg::LimitWidth'(PixelCap);
      if ({2'b00, pixel_count} > max_wide) begin
         limit = max_wide[dvd_pkg::CountWidth-1:0];
      end else begin
         limit = pixel_count;
      end

      payload_shifted = dvd_pkg::PixelWidth'(code_byte[dvd_pkg::PayloadBits-1:0]) << bit_offset_ff;
      code_word       = code_accum_ff | payload_shifted;
      finish          = !code_byte[dvd_pkg::ContinueBit] ||
                        ({1'b0, bit_offset_ff} + 5'(dvd_pkg::PayloadBits) >
                         5'(dvd_pkg::CodeMaxOffset));
      at_limit        = pixels_done_ff >= limit;
      emit            = !dropping_ff && finish && !at_limit;
      drop_now        = !dropping_ff && finish && at_limit;
      drop_after      = dropping_ff || drop_now;

      diff      = {1'b0, code_word[dvd_pkg::PixelWidth-1:1]} ^
                  {dvd_pkg::PixelWidth{code_word[0]}};
      pixel_sum = last_pixel_ff + diff;

      done_after = emit ? pixels_done_ff + dvd_pkg::CountWidth'(1) : pixels_done_ff;
      fill       = (done_after < limit) ? limit - done_after : '0;

      pixel_res.kind        = dvd_pkg::KIND_PIXEL;
      pixel_res.overflowed  = 1'b0;
      pixel_res.zero_fill   = '0;
      pixel_res.pixel_value = pixel_sum;

      summary_res.kind        = dvd_pkg::KIND_SUMMARY;
      summary_res.overflowed  = drop_after;
      summary_res.zero_fill   = fill;
      summary_res.pixel_value = '0;

      push.first  = emit ? pixel_res : summary_res;
      push.second = summary_res;
      push.count  = fire ? dvd_pkg::PushCountWidth'(emit) + dvd_pkg::PushCountWidth'(frame_end)
                         : '0;

      code_accum_in  = code_accum_ff;
      bit_offset_in  = bit_offset_ff;
      last_pixel_in  = last_pixel_ff;
      pixels_done_in = pixels_done_ff;
      dropping_in    = dropping_ff;
      if (fire) begin
         if (frame_end) begin
            code_accum_in  = '0;
            bit_offset_in  = '0;
            last_pixel_in  = '0;
            pixels_done_in = '0;
            dropping_in    = 1'b0;
         end else if (!dropping_ff) begin
            if (finish) begin
               code_accum_in = '0;
               bit_offset_in = '0;
               dropping_in   = drop_after;
               if (emit) begin
                  last_pixel_in  = pixel_sum;
                  pixels_done_in = done_after;
               end
            end else begin
               code_accum_in = code_word;
               bit_offset_in = bit_offset_ff + dvd_pkg::OffsetWidth'(dvd_pkg::PayloadBits);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_accum_ff  <= '0;
         bit_offset_ff  <= '0;
         last_pixel_ff  <= '0;
         pixels_done_ff <= '0;
         dropping_ff    <= 1'b0;
      end else begin
         code_accum_ff  <= code_accum_in;
         bit_offset_ff  <= bit_offset_in;
         last_pixel_ff  <= last_pixel_in;
         pixels_done_ff <= pixels_done_in;
         dropping_ff    <= dropping_in;
      end
   end

endmodule

[rtl/dvd_result_fifo.sv]
// small result queue that takes up to two results per cycle and gives one
module dvd_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  dvd_pkg::push_type    push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dvd_pkg::result_type  out_data
);

   dvd_pkg::result_type                entries_ff [dvd_pkg::FifoDepth];
   logic [dvd_pkg::FifoAddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dvd_pkg::FifoAddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dvd_pkg::FifoCountWidth-1:0] count_ff, count_in;
   logic [dvd_pkg::FifoAddrWidth-1:0]  wr_next;
   logic                               pop;

   always_comb begin
      out_valid = count_ff != '0;
      pop       = out_valid && out_ready;
      out_data  = entries_ff[rd_ptr_ff];
      room      = count_ff <= dvd_pkg::FifoCountWidth'(dvd_pkg::FifoDepth - 2);
      wr_next   = wr_ptr_ff + dvd_pkg::FifoAddrWidth'(1);
      wr_ptr_in = wr_ptr_ff + dvd_pkg::FifoAddrWidth'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + dvd_pkg::FifoAddrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + dvd_pkg::FifoCountWidth'(push.count)
                  - dvd_pkg::FifoCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == dvd_pkg::PushCountWidth'(2)) begin
         entries_ff[wr_next] <= push.second;
      end
   end

endmodule

[rtl/depth_varint_delta_decoder_core.sv]
// top level of the depth varint delta decoder
//
// req channel: one compressed byte per transfer in req_tdata, req_tlast on the
// last byte of a frame. rsp channel: decoded pixels (rsp_tuser low) and one
// end-of-frame summary per frame (rsp_tuser high) with the zero pixels still
// missing and the overflow flag; a pixel finished by the last byte comes
// before the summary.
// csr port: csr_write_enable writes the pixel count of a frame, applied to the
// codes that finish after the write; it resets to 307200.
// an accepted byte waits in the input register, is decoded once the queue has
// room, and its results are written into the result queue that drives rsp.
// throughput: one byte per cycle while the queue has room, set by the single
// decode stage; a last byte that also finishes a code yields two results,
// which leave on rsp one after the other.
// a four-entry result queue absorbs rsp stalls; req_tready falls once the
// queue cannot take two more results and the input register is full.
// reset clears the input register, the queue and all decoding state.
module depth_varint_delta_decoder_core #(
   parameter int PixelCap = dvd_pkg::PixelCap
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dvd_pkg::CodeByteWidth-1:0]  req_tdata,   // code_byte
   input  logic                               req_tlast,   // frame_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dvd_pkg::RspDataWidth-1:0]   rsp_tdata,   // pixel_value, zero_fill, overflowed
   output logic                               rsp_tuser,   // kind
   input  logic                               csr_write_enable,
   input  logic [dvd_pkg::CountWidth-1:0]     csr_write_data
);

   logic                               in_valid_ff, in_valid_in;
   logic [dvd_pkg::CodeByteWidth-1:0]  in_byte_ff;
   logic                               in_last_ff;
   logic [dvd_pkg::CountWidth-1:0]     pixel_count_ff;
   logic                               room;
   logic                               fire;
   logic                               accept;
   dvd_pkg::push_type                  push;
   dvd_pkg::result_type                out_data;

   always_comb begin
      fire        = in_valid_ff && room;
      req_tready  = !in_valid_ff || fire;
      accept      = req_tvalid && req_tready;
      in_valid_in = accept || (in_valid_ff && !fire);
      rsp_tdata   = {out_data.overflowed, out_data.zero_fill, out_data.pixel_value};
      rsp_tuser   = out_data.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pixel_count_ff <= dvd_pkg::PixelCountReset;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            pixel_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dvd_decode #(
      .PixelCap (PixelCap)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .code_byte   (in_byte_ff),
      .frame_end   (in_last_ff),
      .pixel_count (pixel_count_ff),
      .push        (push)
   );

   dvd_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

endmodule

[rtl/dvd_checker.sv]
// port-level checks of the depth varint delta decoder, bound to the top level
module dvd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dvd_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dvd_pkg::KIND_PIXEL) |-> rsp_tdata[39:16] == '0)
      else $error("pixel result carries summary fields");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dvd_pkg::KIND_SUMMARY) |-> rsp_tdata[15:0] == '0)
      else $error("summary result carries a pixel value");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("queue or input register not empty after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the result queue empty");

endmodule

bind depth_varint_delta_decoder_core dvd_checker u_dvd_checker (.*);
